### sv/point_in_triangle_barycentric_top_defines.svh
// Assertion macros for the barycentric point-in-triangle block
`ifndef POINT_IN_TRIANGLE_BARYCENTRIC_TOP_DEFINES_SVH
`define POINT_IN_TRIANGLE_BARYCENTRIC_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define PTB_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define PTB_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define PTB_ASSERT_IMP(label, clk, rst, a, c)
`define PTB_ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

### sv/ptb_pkg.sv
// Shared types and constants for the barycentric point-in-triangle block
`default_nettype none
package ptb_pkg;
  localparam int CoordWidth  = 16;
  localparam int FracBits    = 16;
  localparam int WeightWidth = FracBits + 2;
  localparam int DiffWidth   = CoordWidth + 1;
  localparam int CrossWidth  = 2 * DiffWidth + 1;
  localparam int MagWidth    = CrossWidth;
  // quotient bits kept: integer part up to 4 (3 bits) plus fraction plus round bit
  localparam int QuotWidth   = FracBits + 4;
  localparam int QueueDepth  = 4;
  localparam int QueueAw     = $clog2(QueueDepth);

  typedef enum logic [2:0] {
    LOC_OUTSIDE    = 3'd0,
    LOC_INSIDE     = 3'd1,
    LOC_EDGE       = 3'd2,
    LOC_VERTEX     = 3'd3,
    LOC_DEGENERATE = 3'd4
  } location_t;

  typedef enum logic [2:0] {
    REG_A_X = 3'd0, REG_A_Y = 3'd1, REG_B_X = 3'd2,
    REG_B_Y = 3'd3, REG_C_X = 3'd4, REG_C_Y = 3'd5
  } reg_index_t;

  // classified item handed from front to back
  typedef struct packed {
    location_t                    location;
    logic                         nb_neg;
    logic                         nc_neg;
    logic [MagWidth-1:0]          nb_mag;
    logic [MagWidth-1:0]          nc_mag;
    logic [MagWidth-1:0]          d_mag;
  } job_t;

  typedef struct packed {
    location_t               location;
    logic [WeightWidth-1:0]  weight_b;
    logic [WeightWidth-1:0]  weight_c;
    logic                    saturated;
  } result_t;
endpackage
`default_nettype wire

### sv/ptb_if.sv
// Valid/ready channel interfaces for points, results and configuration
`default_nettype none
interface ptb_point_if;
  logic                            valid;
  logic                            ready;
  logic signed [ptb_pkg::CoordWidth-1:0] point_x;
  logic signed [ptb_pkg::CoordWidth-1:0] point_y;
  modport source (output valid, point_x, point_y, input ready);
  modport sink (input valid, point_x, point_y, output ready);
endinterface

interface ptb_result_if;
  logic                                   valid;
  logic                                   ready;
  logic [2:0]                             location;
  logic signed [ptb_pkg::WeightWidth-1:0] weight_b;
  logic signed [ptb_pkg::WeightWidth-1:0] weight_c;
  logic                                   saturated;
  modport source (output valid, location, weight_b, weight_c, saturated, input ready);
  modport sink (input valid, location, weight_b, weight_c, saturated, output ready);
endinterface

interface ptb_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [2:0]                            index;
  logic [ptb_pkg::CoordWidth-1:0]        data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### sv/ptb_front.sv
// Front: vertex registers, cross products and classification (3 stages)
`default_nettype none
module ptb_front (
  input  wire logic          clk,
  input  wire logic          rst,
  ptb_cfg_if.sink            cfg,
  ptb_point_if.sink          pt,
  input  wire logic          stall,
  output logic               job_valid,
  output ptb_pkg::job_t      job
);
  import ptb_pkg::*;

  logic signed [CoordWidth-1:0] ax, ay, bx, by, cx, cy;
  logic s1_valid, s2_valid, s3_valid;
  logic signed [DiffWidth-1:0] bax, bay, cax, cay, pax, pay, bpx, bpy, cpx, cpy;
  logic signed [CrossWidth-1:0] m_d0, m_d1, m_a0, m_a1, m_b0, m_b1, m_c0, m_c1;
  logic signed [CrossWidth-1:0] d, na, nb, nc;
  logic signed [CrossWidth-1:0] d_n, nb_n, nc_n;
  logic       s_neg, a_opp, b_opp, c_opp;
  logic [1:0] zeros;
  location_t  loc;

  assign cfg.ready = 1'b1;
  assign pt.ready  = !stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      ax <= '0; ay <= '0; bx <= '0; by <= '0; cx <= '0; cy <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_A_X: ax <= cfg.data;
        REG_A_Y: ay <= cfg.data;
        REG_B_X: bx <= cfg.data;
        REG_B_Y: by <= cfg.data;
        REG_C_X: cx <= cfg.data;
        REG_C_Y: cy <= cfg.data;
        default: ;
      endcase
    end
  end

  // stage 1: differences
  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else if (!stall) s1_valid <= pt.valid;
    if (!stall) begin
      bax <= DiffWidth'(bx) - DiffWidth'(ax);
      bay <= DiffWidth'(by) - DiffWidth'(ay);
      cax <= DiffWidth'(cx) - DiffWidth'(ax);
      cay <= DiffWidth'(cy) - DiffWidth'(ay);
      pax <= DiffWidth'(pt.point_x) - DiffWidth'(ax);
      pay <= DiffWidth'(pt.point_y) - DiffWidth'(ay);
      bpx <= DiffWidth'(bx) - DiffWidth'(pt.point_x);
      bpy <= DiffWidth'(by) - DiffWidth'(pt.point_y);
      cpx <= DiffWidth'(cx) - DiffWidth'(pt.point_x);
      cpy <= DiffWidth'(cy) - DiffWidth'(pt.point_y);
    end
  end

  // stage 2: products; stage 3: cross differences
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (!stall) begin
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
    if (!stall) begin
      m_d0 <= CrossWidth'(bax * cay); m_d1 <= CrossWidth'(bay * cax);
      m_a0 <= CrossWidth'(bpx * cpy); m_a1 <= CrossWidth'(bpy * cpx);
      m_b0 <= CrossWidth'(pax * cay); m_b1 <= CrossWidth'(pay * cax);
      m_c0 <= CrossWidth'(bax * pay); m_c1 <= CrossWidth'(bay * pax);
      d  <= m_d0 - m_d1;
      na <= m_a0 - m_a1;
      nb <= m_b0 - m_b1;
      nc <= m_c0 - m_c1;
    end
  end

  always_comb begin
    d_n  = -d;
    nb_n = -nb;
    nc_n = -nc;
    s_neg = d[CrossWidth-1];
    // opposite sign to D, ignoring zero
    a_opp = (na != '0) && (na[CrossWidth-1] != s_neg);
    b_opp = (nb != '0) && (nb[CrossWidth-1] != s_neg);
    c_opp = (nc != '0) && (nc[CrossWidth-1] != s_neg);
    zeros = 2'((na == '0)) + 2'((nb == '0)) + 2'((nc == '0));
    if (d == '0) loc = LOC_DEGENERATE;
    else if (a_opp || b_opp || c_opp) loc = LOC_OUTSIDE;
    else if (zeros >= 2'd2) loc = LOC_VERTEX;
    else if (zeros == 2'd1) loc = LOC_EDGE;
    else loc = LOC_INSIDE;
    job.location = loc;
    job.nb_mag   = nb[CrossWidth-1] ? nb_n : nb;
    job.nc_mag   = nc[CrossWidth-1] ? nc_n : nc;
    job.d_mag    = s_neg ? d_n : d;
    job.nb_neg   = nb[CrossWidth-1] ^ s_neg;
    job.nc_neg   = nc[CrossWidth-1] ^ s_neg;
    job_valid    = s3_valid && !stall;
  end
endmodule
`default_nettype wire

### sv/ptb_queue.sv
// Short FIFO between front and back
`default_nettype none
module ptb_queue (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  ptb_pkg::job_t  push_data,
  input  wire logic      pop,
  output logic           not_empty,
  output logic           full,
  output ptb_pkg::job_t  pop_data
);
  import ptb_pkg::*;

  job_t mem [QueueDepth];
  logic [QueueAw-1:0] wr_ptr, rd_ptr;
  logic [QueueAw:0]   count;

  assign not_empty = count != '0;
  // the front freezes in the same cycle, so no beat in flight is lost
  assign full = count == (QueueAw+1)'(QueueDepth);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QueueAw+1)'(push) - (QueueAw+1)'(pop);
    end
    if (push) mem[wr_ptr] <= push_data;
  end
endmodule
`default_nettype wire

### sv/ptb_back.sv
// Back: pipelined restoring dividers for both weights, rounding, saturation
`default_nettype none
module ptb_back (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  ptb_pkg::job_t   job,
  ptb_result_if.source    res
);
  import ptb_pkg::*;

  // one quotient bit per stage: 3 integer bits, FracBits fraction, 1 round
  localparam int Steps = 3 + FracBits + 1;

  typedef struct packed {
    logic                  valid;
    location_t             location;
    logic                  b_neg;
    logic                  c_neg;
    logic [MagWidth-1:0]   d_mag;
    logic [MagWidth+3:0]   b_rem;
    logic [MagWidth+3:0]   c_rem;
    logic [QuotWidth:0]    b_q;
    logic [QuotWidth:0]    c_q;
    logic                  b_big;
    logic                  c_big;
  } stage_t;

  stage_t st [Steps+1];
  logic   adv;
  logic [WeightWidth:0] b_fin, c_fin;
  logic b_sat, c_sat;
  logic [WeightWidth-1:0] wb, wc;

  assign adv      = !res.valid || res.ready;
  assign in_ready = adv;

  // stage 0: remainders start as the plain magnitude; the rem is doubled
  // from the last integer step on, and the last step is the round bit;
  // integer part > 4 clips to 4 via the big flag
  always_comb begin
    st[0].valid    = in_valid;
    st[0].location = job.location;
    st[0].b_neg    = job.nb_neg;
    st[0].c_neg    = job.nc_neg;
    st[0].d_mag    = job.d_mag;
    st[0].b_rem    = (MagWidth+4)'(job.nb_mag);
    st[0].c_rem    = (MagWidth+4)'(job.nc_mag);
    st[0].b_q      = '0;
    st[0].c_q      = '0;
    st[0].b_big    = (MagWidth+3)'(job.nb_mag) >= ((MagWidth+3)'(job.d_mag) * 5);
    st[0].c_big    = (MagWidth+3)'(job.nc_mag) >= ((MagWidth+3)'(job.d_mag) * 5);
  end

  for (genvar k = 0; k < Steps; k++) begin : g_div
    localparam int Sh = (k < 3) ? (2 - k) : 0;
    logic [MagWidth+3:0] db, bt, ct;
    logic bb, cb;
    always_comb begin
      // integer bits compare against d << Sh; fraction bits use doubled rem
      db = (MagWidth+4)'(st[k].d_mag) << Sh;
      bt = st[k].b_rem;
      ct = st[k].c_rem;
      bb = bt >= db;
      cb = ct >= db;
    end
    always_ff @(posedge clk) begin
      if (rst) st[k+1].valid <= 1'b0;
      else if (adv) st[k+1].valid <= st[k].valid;
      if (adv) begin
        st[k+1].location <= st[k].location;
        st[k+1].b_neg <= st[k].b_neg;
        st[k+1].c_neg <= st[k].c_neg;
        st[k+1].d_mag <= st[k].d_mag;
        st[k+1].b_big <= st[k].b_big;
        st[k+1].c_big <= st[k].c_big;
        st[k+1].b_q <= {st[k].b_q[QuotWidth-1:0], bb};
        st[k+1].c_q <= {st[k].c_q[QuotWidth-1:0], cb};
        if (k < 2) begin
          st[k+1].b_rem <= bb ? bt - db : bt;
          st[k+1].c_rem <= cb ? ct - db : ct;
        end else begin
          st[k+1].b_rem <= (bb ? bt - db : bt) << 1;
          st[k+1].c_rem <= (cb ? ct - db : ct) << 1;
        end
      end
    end
  end

  always_comb begin
    // q has Steps bits: int(3), frac(FracBits), round(1)
    b_fin = st[Steps].b_big ? (WeightWidth+1)'(4 << FracBits)
          : (WeightWidth+1)'(st[Steps].b_q[Steps-1:1]) + (WeightWidth+1)'(st[Steps].b_q[0]);
    c_fin = st[Steps].c_big ? (WeightWidth+1)'(4 << FracBits)
          : (WeightWidth+1)'(st[Steps].c_q[Steps-1:1]) + (WeightWidth+1)'(st[Steps].c_q[0]);
    if (st[Steps].b_neg) begin
      b_sat = b_fin > (WeightWidth+1)'(1 << (FracBits+1));
      wb = b_sat ? WeightWidth'(1 << (FracBits+1)) : WeightWidth'(-b_fin);
    end else begin
      b_sat = b_fin > (WeightWidth+1)'((1 << (FracBits+1)) - 1);
      wb = b_sat ? WeightWidth'((1 << (FracBits+1)) - 1) : WeightWidth'(b_fin);
    end
    if (st[Steps].c_neg) begin
      c_sat = c_fin > (WeightWidth+1)'(1 << (FracBits+1));
      wc = c_sat ? WeightWidth'(1 << (FracBits+1)) : WeightWidth'(-c_fin);
    end else begin
      c_sat = c_fin > (WeightWidth+1)'((1 << (FracBits+1)) - 1);
      wc = c_sat ? WeightWidth'((1 << (FracBits+1)) - 1) : WeightWidth'(c_fin);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) res.valid <= 1'b0;
    else if (adv) res.valid <= st[Steps].valid;
    if (adv) begin
      res.location <= st[Steps].location;
      if (st[Steps].location == LOC_DEGENERATE) begin
        res.weight_b  <= '0;
        res.weight_c  <= '0;
        res.saturated <= 1'b0;
      end else begin
        res.weight_b  <= wb;
        res.weight_c  <= wc;
        res.saturated <= b_sat || c_sat;
      end
    end
  end
endmodule
`default_nettype wire

### sv/point_in_triangle_barycentric_top.sv
// A point beat becomes a result beat through 3 front stages, one
// queue slot, 20 divider stages and the output register.
// Throughput: one point per cycle unless the 4-deep queue is full, which a
// stalled result fills first; one quotient bit per stage for both weights.
// Reset (rst, synchronous) clears vertices to 0 and empties the pipes.
`default_nettype none
`include "point_in_triangle_barycentric_top_defines.svh"
module point_in_triangle_barycentric_top (
  input wire logic     clk,
  input wire logic     rst,
  ptb_cfg_if.sink      cfg,
  ptb_point_if.sink    pt,
  ptb_result_if.source res
);
  import ptb_pkg::*;

  logic  job_valid, q_ne, q_full, back_ready, front_stall;
  job_t  job, q_job;

  // front stalls only while the queue is full
  assign front_stall = q_full;

  ptb_front u_front (
    .clk(clk), .rst(rst), .cfg(cfg), .pt(pt), .stall(front_stall),
    .job_valid(job_valid), .job(job)
  );

  ptb_queue u_queue (
    .clk(clk), .rst(rst), .push(job_valid), .push_data(job),
    .pop(q_ne && back_ready), .not_empty(q_ne), .full(q_full),
    .pop_data(q_job)
  );

  ptb_back u_back (
    .clk(clk), .rst(rst), .in_valid(q_ne && back_ready), .in_ready(back_ready),
    .job(q_job), .res(res)
  );

  `PTB_ASSERT_IMP(a_no_overflow, clk, rst, q_full, !job_valid)
  `PTB_ASSERT_IMP(a_degen_zero, clk, rst, res.valid && res.location == LOC_DEGENERATE,
    res.weight_b == '0 && res.weight_c == '0 && !res.saturated)
  `PTB_ASSERT_NEXT(a_hold, clk, rst, res.valid && !res.ready, res.valid)
endmodule
`default_nettype wire
